FILE: hdl/trp_pkg.sv
// ----------------------------------------------------------------------------
// trp_pkg
// Shared types and codes of the thermostat relay protection block.
// ----------------------------------------------------------------------------
package trp_pkg;

    localparam int COUNT_W    = 16;
    localparam int HYST_W     = 13;
    localparam int MINSAMP_W  = 12;
    localparam int RENOTIFY_W = 27;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [2:0] {
        NOTICE_NONE        = 3'd0,
        NOTICE_HEAT_START  = 3'd1,
        NOTICE_COOL_START  = 3'd2,
        NOTICE_CLEARED     = 3'd3,
        NOTICE_HEAT_REMIND = 3'd4,
        NOTICE_COOL_REMIND = 3'd5
    } t_notice;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE     = 3'd0,
        CFG_LOWER      = 3'd1,
        CFG_UPPER      = 3'd2,
        CFG_HYST       = 3'd3,
        CFG_MIN_SAMP   = 3'd4,
        CFG_RENOTIFY   = 3'd5,
        CFG_MIN_SWITCH = 3'd6
    } t_cfg_reg;

    // decision for one item: new relay drive, notice and timer updates
    typedef struct packed {
        logic    heat;
        logic    cool;
        t_notice notice;
        logic    upd_switch;
        logic    upd_heat_t;
        logic    upd_cool_t;
    } t_trp_dec;

endpackage

FILE: hdl/trp_decide.sv
// ----------------------------------------------------------------------------
// trp_decide
// Relay decision for one temperature report: hysteresis, midpoint release,
// conflict resolution, switch holdoff and reminder timing.
// ----------------------------------------------------------------------------
module trp_decide
    import trp_pkg::*;
#(
    parameter int TEMP_WIDTH = 13,
    parameter int TIME_WIDTH = 32
) (
    input  logic                         i_enable,
    input  logic signed [TEMP_WIDTH-1:0] i_lower,
    input  logic signed [TEMP_WIDTH-1:0] i_upper,
    input  logic [HYST_W-1:0]            i_hyst,
    input  logic [MINSAMP_W-1:0]         i_min_samples,
    input  logic [RENOTIFY_W-1:0]        i_renotify,
    input  logic [TIME_WIDTH-1:0]        i_min_switch,
    input  logic                         i_heating,
    input  logic                         i_cooling,
    input  logic [TIME_WIDTH-1:0]        i_last_switch,
    input  logic [TIME_WIDTH-1:0]        i_last_heat,
    input  logic [TIME_WIDTH-1:0]        i_last_cool,
    input  logic [COUNT_W-1:0]           i_count,
    input  logic signed [TEMP_WIDTH-1:0] i_cur,
    input  logic [TIME_WIDTH-1:0]        i_time,
    output t_trp_dec                     o_dec
);

    localparam int EW = ((TEMP_WIDTH > HYST_W) ? TEMP_WIDTH : HYST_W) + 3;
    localparam int CW = (TIME_WIDTH > RENOTIFY_W) ? TIME_WIDTH : RENOTIFY_W;

    logic signed [EW-1:0] cur_e, lo_e, hi_e, hy_e, diff, diff_abs;
    logic [TIME_WIDTH-1:0] el_switch, el_heat, el_cool;
    logic enough, active, near_mid, want_heat, want_cool, base_heat, base_cool;
    logic change, too_soon, rem_heat, rem_cool, idle_refresh;

    always_comb begin
        cur_e = EW'(i_cur);
        lo_e  = EW'(i_lower);
        hi_e  = EW'(i_upper);
        hy_e  = EW'(i_hyst);

        enough = COUNT_W'(i_min_samples) <= i_count;
        active = i_enable && (i_count != '0) && (i_heating || i_cooling || enough);

        base_heat = i_heating ? (cur_e < lo_e + hy_e) : (cur_e <= lo_e);
        base_cool = i_cooling ? (cur_e > hi_e - hy_e) : (cur_e >= hi_e);

        diff     = (cur_e <<< 1) - (lo_e + hi_e);
        diff_abs = diff[EW-1] ? -diff : diff;
        near_mid = (cur_e > lo_e) && (cur_e < hi_e) && (diff_abs <= (hy_e <<< 1));

        want_heat = base_heat;
        want_cool = base_cool;
        if ((i_heating || i_cooling) && near_mid) begin
            want_heat = 1'b0;
            want_cool = 1'b0;
        end
        // both wanted: the side beyond its limit wins, otherwise release both
        if (want_heat && want_cool) begin
            if (cur_e <= lo_e) begin
                want_cool = 1'b0;
            end else if (cur_e >= hi_e) begin
                want_heat = 1'b0;
            end else begin
                want_heat = 1'b0;
                want_cool = 1'b0;
            end
        end

        el_switch = i_time - i_last_switch;
        el_heat   = i_time - i_last_heat;
        el_cool   = i_time - i_last_cool;

        change   = (want_heat != i_heating) || (want_cool != i_cooling);
        too_soon = (i_last_switch != '0) && (el_switch < i_min_switch);
        rem_heat = i_heating && (CW'(el_heat) >= CW'(i_renotify));
        rem_cool = i_cooling && (CW'(el_cool) >= CW'(i_renotify));
        idle_refresh = !i_heating && !i_cooling && enough;

        o_dec.heat       = i_heating;
        o_dec.cool       = i_cooling;
        o_dec.notice     = NOTICE_NONE;
        o_dec.upd_switch = 1'b0;
        o_dec.upd_heat_t = 1'b0;
        o_dec.upd_cool_t = 1'b0;

        if (active) begin
            if (change) begin
                if (!too_soon) begin
                    o_dec.heat       = want_heat;
                    o_dec.cool       = want_cool;
                    o_dec.upd_switch = 1'b1;
                    if (want_heat) begin
                        o_dec.notice     = NOTICE_HEAT_START;
                        o_dec.upd_heat_t = 1'b1;
                    end else if (want_cool) begin
                        o_dec.notice     = NOTICE_COOL_START;
                        o_dec.upd_cool_t = 1'b1;
                    end else begin
                        o_dec.notice     = NOTICE_CLEARED;
                        o_dec.upd_heat_t = 1'b1;
                        o_dec.upd_cool_t = 1'b1;
                    end
                end
            end else begin
                if (rem_heat) begin
                    o_dec.notice = NOTICE_HEAT_REMIND;
                end else if (rem_cool) begin
                    o_dec.notice = NOTICE_COOL_REMIND;
                end
                o_dec.upd_heat_t = rem_heat || idle_refresh;
                o_dec.upd_cool_t = rem_cool || idle_refresh;
            end
        end
    end

endmodule

FILE: hdl/thermostat_relay_protection.sv
// ----------------------------------------------------------------------------
// thermostat_relay_protection
// Bang-bang thermostat with hysteresis driving a heating and a cooling relay.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the slave stream is one temperature report (sample count,
//   latest and average reading, millisecond timestamp). Each report gives
//   exactly one item on the master stream: both relay drives after the
//   report, a notice code and the two readings echoed.
//   A report is first held in the input register; the decision logic then
//   feeds the result register, which drives the master stream. One item
//   is accepted per cycle when the output side keeps tready high; the relay
//   state is updated as an item moves into the result register, so the
//   next item sees it without delay.
//   When the receiver stalls, the result register holds and the input
//   register can still take one more item; after that tready drops.
//   The configuration channel is always ready; write only while no items
//   are in flight. Unknown indexes are ignored.
//   Reset (synchronous, active low) empties both stages, turns both relays
//   off, clears the switch and reminder timers and loads register defaults.
// ----------------------------------------------------------------------------
module thermostat_relay_protection
    import trp_pkg::*;
#(
    parameter int TEMP_WIDTH = 13,
    parameter int TIME_WIDTH = 32,
    localparam int IN_W  = ((COUNT_W + 2 * TEMP_WIDTH + TIME_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((5 + 2 * TEMP_WIDTH + 7) / 8) * 8,
    localparam int CFG_W = (TIME_WIDTH > TEMP_WIDTH)
                           ? ((TIME_WIDTH > RENOTIFY_W) ? TIME_WIDTH : RENOTIFY_W)
                           : ((TEMP_WIDTH > RENOTIFY_W) ? TEMP_WIDTH : RENOTIFY_W)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // sample_count, current_temp, average_temp, time_ms, zero pad
    input  logic [IN_W-1:0]      i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // heating_relay, cooling_relay, notice, report_current, report_average, zero pad
    output logic [OUT_W-1:0]     o_m_axis_tdata,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CUR_LO  = COUNT_W;
    localparam int AVG_LO  = COUNT_W + TEMP_WIDTH;
    localparam int TIME_LO = COUNT_W + 2 * TEMP_WIDTH;

    // configuration registers
    logic                         r_enable;
    logic signed [TEMP_WIDTH-1:0] r_lower;
    logic signed [TEMP_WIDTH-1:0] r_upper;
    logic [HYST_W-1:0]            r_hyst;
    logic [MINSAMP_W-1:0]         r_min_samples;
    logic [RENOTIFY_W-1:0]        r_renotify;
    logic [TIME_WIDTH-1:0]        r_min_switch;

    // relay state
    logic                  r_heating;
    logic                  r_cooling;
    logic [TIME_WIDTH-1:0] r_last_switch;
    logic [TIME_WIDTH-1:0] r_last_heat;
    logic [TIME_WIDTH-1:0] r_last_cool;

    // input stage
    logic                         r_s1_valid;
    logic [COUNT_W-1:0]           r_s1_count;
    logic signed [TEMP_WIDTH-1:0] r_s1_cur;
    logic signed [TEMP_WIDTH-1:0] r_s1_avg;
    logic [TIME_WIDTH-1:0]        r_s1_time;

    // result stage
    logic                         r_out_valid;
    logic                         r_out_heat;
    logic                         r_out_cool;
    t_notice                      r_out_notice;
    logic signed [TEMP_WIDTH-1:0] r_out_cur;
    logic signed [TEMP_WIDTH-1:0] r_out_avg;

    t_trp_dec n_dec;
    logic     advance;
    logic     in_accept;
    logic     cfg_write;

    assign advance         = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || advance;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign cfg_write       = i_cfg_valid;

    trp_decide #(
        .TEMP_WIDTH (TEMP_WIDTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_decide (
        .i_enable      (r_enable),
        .i_lower       (r_lower),
        .i_upper       (r_upper),
        .i_hyst        (r_hyst),
        .i_min_samples (r_min_samples),
        .i_renotify    (r_renotify),
        .i_min_switch  (r_min_switch),
        .i_heating     (r_heating),
        .i_cooling     (r_cooling),
        .i_last_switch (r_last_switch),
        .i_last_heat   (r_last_heat),
        .i_last_cool   (r_last_cool),
        .i_count       (r_s1_count),
        .i_cur         (r_s1_cur),
        .i_time        (r_s1_time),
        .o_dec         (n_dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b1;
            r_lower       <= TEMP_WIDTH'(160);
            r_upper       <= TEMP_WIDTH'(480);
            r_hyst        <= HYST_W'(16);
            r_min_samples <= MINSAMP_W'(1);
            r_renotify    <= RENOTIFY_W'(600000);
            r_min_switch  <= TIME_WIDTH'(10000);
        end else if (cfg_write) begin
            case (i_cfg_index)
                CFG_ENABLE:     r_enable      <= i_cfg_data[0];
                CFG_LOWER:      r_lower       <= i_cfg_data[TEMP_WIDTH-1:0];
                CFG_UPPER:      r_upper       <= i_cfg_data[TEMP_WIDTH-1:0];
                CFG_HYST:       r_hyst        <= i_cfg_data[HYST_W-1:0];
                CFG_MIN_SAMP:   r_min_samples <= i_cfg_data[MINSAMP_W-1:0];
                CFG_RENOTIFY:   r_renotify    <= i_cfg_data[RENOTIFY_W-1:0];
                CFG_MIN_SWITCH: r_min_switch  <= i_cfg_data[TIME_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heating     <= 1'b0;
            r_cooling     <= 1'b0;
            r_last_switch <= '0;
            r_last_heat   <= '0;
            r_last_cool   <= '0;
        end else if (advance) begin
            r_heating <= n_dec.heat;
            r_cooling <= n_dec.cool;
            if (n_dec.upd_switch) begin
                r_last_switch <= r_s1_time;
            end
            if (n_dec.upd_heat_t) begin
                r_last_heat <= r_s1_time;
            end
            if (n_dec.upd_cool_t) begin
                r_last_cool <= r_s1_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_count <= i_s_axis_tdata[COUNT_W-1:0];
            r_s1_cur   <= i_s_axis_tdata[CUR_LO +: TEMP_WIDTH];
            r_s1_avg   <= i_s_axis_tdata[AVG_LO +: TEMP_WIDTH];
            r_s1_time  <= i_s_axis_tdata[TIME_LO +: TIME_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_heat   <= n_dec.heat;
            r_out_cool   <= n_dec.cool;
            r_out_notice <= n_dec.notice;
            r_out_cur    <= r_s1_cur;
            r_out_avg    <= r_s1_avg;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_avg, r_out_cur, r_out_notice, r_out_cool,
                                     r_out_heat});

endmodule
